>>> design/msb_first_bit_reader_assert.svh
// Assertion macros shared by the bit reader RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef MSB_FIRST_BIT_READER_ASSERT_SVH
`define MSB_FIRST_BIT_READER_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define MFBR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bit reader assertion failed");
// A condition at one edge that forces a property at the next edge.
`define MFBR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bit reader assertion failed");
`else
`define MFBR_ASSERT(label, clk, rst, prop)
`define MFBR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> design/mfbr_pkg.sv
package mfbr_pkg;

   // Fixed field widths and limits.
   localparam int BYTE_BITS     = 8;
   localparam int MAX_READ_BITS = 64;
   localparam int ACC_BITS      = 72;
   localparam int BITS_LEFT_W   = 10;
   localparam int COUNT_W       = 7;
   localparam int SPAN_W        = 4;

   // A read of up to 64 bits at any offset touches at most nine bytes.
   localparam logic [SPAN_W-1:0] MAX_SPAN_BYTES = 4'd9;

   // Request codes.
   localparam logic [1:0] REQ_FILL = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_PEEK = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_COUNT = 2'd1;
   localparam logic [1:0] STAT_SHORT     = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [BYTE_BITS-1:0] fill_byte;
      logic [COUNT_W-1:0]   bit_count;
   } mfbr_req_type;

   typedef struct packed {
      logic [MAX_READ_BITS-1:0] value;
      logic [1:0]               status;
      logic [BITS_LEFT_W-1:0]   bits_left;
   } mfbr_rsp_type;

   // Control from the sequencer to the gather unit.
   typedef struct packed {
      logic               clear;
      logic               shift_en;
      logic [2:0]         pad;
      logic [COUNT_W-1:0] count;
   } mfbr_gather_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_GATHER,
      ST_FINISH
   } mfbr_state_type;

endpackage

>>> design/mfbr_byte_store.sv
module mfbr_byte_store
   import mfbr_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BYTE_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BYTE_BITS-1:0]     rd_data
);

   logic [BYTE_BITS-1:0] mem [DEPTH];
   logic [BYTE_BITS-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mfbr_gather.sv
module mfbr_gather
   import mfbr_pkg::*;
(
   input  logic                     clock,
   input  mfbr_gather_ctrl_type     ctrl,
   input  logic [BYTE_BITS-1:0]     byte_in,
   output logic [MAX_READ_BITS-1:0] value
);

   logic [ACC_BITS-1:0]      acc_ff;
   logic [ACC_BITS-1:0]      acc_in;
   logic [ACC_BITS-1:0]      shifted;
   logic [MAX_READ_BITS-1:0] mask;

   // Bytes shift in from the right, so the first byte ends up most significant.
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.shift_en) begin
         acc_in = {acc_ff[ACC_BITS-BYTE_BITS-1:0], byte_in};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Drop the unused tail bits of the last byte, then keep only the bits asked for.
   always_comb begin
      shifted = acc_ff >> ctrl.pad;
      mask    = {MAX_READ_BITS{1'b1}} >> (COUNT_W'(MAX_READ_BITS) - ctrl.count);
      value   = shifted[MAX_READ_BITS-1:0] & mask;
   end

endmodule

>>> design/msb_first_bit_reader.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  mfbr_req_type  (req_type, fill_byte, bit_count)
// rsp       out        rsp_valid / rsp_ready  mfbr_rsp_type  (value, status, bits_left)
//
// A fill, a rejected request or an unused code goes from evaluation straight to the finish state.
// A read or peek over k bytes, with k = ceil((offset + count) / 8) and so 1 to 9, fetches them
// through the single read port of the byte store, which fetches one byte a cycle.
// Reset is synchronous and clears the read position and fill level; the byte store has no clear.
// A result waits in the output register while the next request is taken; the block
// stalls before loading a new result only while the previous one is still held.
`include "msb_first_bit_reader_assert.svh"

module msb_first_bit_reader
   import mfbr_pkg::*;
#(
   parameter int BUFFER_BYTES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mfbr_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mfbr_rsp_type rsp_data
);

   localparam int AW  = $clog2(BUFFER_BYTES);
   localparam int LW  = $clog2(BUFFER_BYTES + 1);
   localparam int SW  = AW + 1;
   localparam int BLW = LW + 3;

   mfbr_state_type           state_ff, state_in;
   mfbr_req_type             req_ff, req_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [2:0]               off_ff, off_in;
   logic [LW-1:0]            level_ff, level_in;
   logic [1:0]               status_ff, status_in;
   logic                     gather_ok_ff, gather_ok_in;
   logic [AW-1:0]            rd_addr_ff, rd_addr_in;
   logic [SPAN_W-1:0]        issue_cnt_ff, issue_cnt_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mfbr_rsp_type             rsp_data_ff, rsp_data_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic                     rd_en;
   logic [BYTE_BITS-1:0]     rd_data;
   mfbr_gather_ctrl_type     gctl;
   logic [MAX_READ_BITS-1:0] gather_value;

   logic [SW-1:0]            fill_sum;
   logic [SW-1:0]            head_sum;
   logic [COUNT_W-1:0]       span;
   logic [COUNT_W-1:0]       span_up;
   logic [SPAN_W-1:0]        span_bytes;
   logic [SPAN_W-1:0]        consumed;
   logic [AW-1:0]            head_adv;
   logic [AW-1:0]            rd_addr_next;
   logic [BLW-1:0]           bits_cur;
   logic [BLW-1:0]           bits_next;
   logic                     count_bad;
   logic                     data_short;

   mfbr_byte_store #(
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.fill_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   mfbr_gather u_gather (
      .clock   (clock),
      .ctrl    (gctl),
      .byte_in (rd_data),
      .value   (gather_value)
   );

   // Position arithmetic for the pending request.
   always_comb begin
      fill_sum   = SW'(head_ff) + SW'(level_ff);
      wr_addr    = (fill_sum >= SW'(BUFFER_BYTES)) ? AW'(fill_sum - SW'(BUFFER_BYTES))
                                                   : AW'(fill_sum);
      span       = COUNT_W'(off_ff) + req_ff.bit_count;
      span_up    = span + COUNT_W'(7);
      span_bytes = span_up[COUNT_W-1:3];
      consumed   = span[COUNT_W-1:3];
      head_sum   = SW'(head_ff) + SW'(consumed);
      head_adv   = (head_sum >= SW'(BUFFER_BYTES)) ? AW'(head_sum - SW'(BUFFER_BYTES))
                                                   : AW'(head_sum);
      rd_addr_next = (rd_addr_ff == AW'(BUFFER_BYTES - 1)) ? '0 : rd_addr_ff + AW'(1);
      bits_cur   = {level_ff, 3'b000} - BLW'(off_ff);
      count_bad  = (req_ff.bit_count == '0) ||
                   (req_ff.bit_count > COUNT_W'(MAX_READ_BITS));
      data_short = bits_cur < BLW'(req_ff.bit_count);
   end

   // Sequencer: evaluate, fetch bytes through the gather unit for a valid read or peek, then post the result.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      off_in       = off_ff;
      level_in     = level_ff;
      status_in    = status_ff;
      gather_ok_in = gather_ok_ff;
      rd_addr_in   = rd_addr_ff;
      issue_cnt_in = issue_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      bits_next    = bits_cur;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      gctl.clear    = 1'b0;
      gctl.shift_en = 1'b0;
      gctl.pad      = 3'd0 - span[2:0];
      gctl.count    = req_ff.bit_count;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            gctl.clear   = 1'b1;
            gather_ok_in = 1'b0;
            status_in    = STAT_OK;
            state_in     = ST_FINISH;
            case (req_ff.req_type)
               REQ_FILL: begin
                  if (level_ff >= LW'(BUFFER_BYTES)) begin
                     status_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     level_in = level_ff + LW'(1);
                  end
               end
               REQ_READ, REQ_PEEK: begin
                  if (count_bad) begin
                     status_in = STAT_BAD_COUNT;
                  end else if (data_short) begin
                     status_in = STAT_SHORT;
                  end else begin
                     gather_ok_in = 1'b1;
                     issue_cnt_in = span_bytes;
                     rd_addr_in   = head_ff;
                     state_in     = ST_GATHER;
                  end
               end
               default: begin
                  // The unused code changes nothing and reports success.
                  status_in = STAT_OK;
               end
            endcase
         end
         ST_GATHER: begin
            gctl.shift_en = rd_valid_ff;
            if (issue_cnt_ff != '0) begin
               rd_en        = 1'b1;
               rd_addr_in   = rd_addr_next;
               issue_cnt_in = issue_cnt_ff - SPAN_W'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               // Only a successful read moves the position.
               if (gather_ok_ff && (req_ff.req_type == REQ_READ)) begin
                  head_in  = head_adv;
                  off_in   = span[2:0];
                  level_in = level_ff - LW'(consumed);
               end
               // Unread bits after this request, from the committed position.
               bits_next             = {level_in, 3'b000} - BLW'(off_in);
               rsp_valid_in          = 1'b1;
               rsp_data_in.value     = gather_ok_ff ? gather_value : '0;
               rsp_data_in.status    = status_ff;
               rsp_data_in.bits_left = BITS_LEFT_W'(bits_next);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_valid_in = rd_en;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         off_ff       <= '0;
         level_ff     <= '0;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         off_ff       <= off_in;
         level_ff     <= level_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      status_ff    <= status_in;
      gather_ok_ff <= gather_ok_in;
      rd_addr_ff   <= rd_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MFBR_ASSERT(a_level_bound, clock, reset, level_ff <= LW'(BUFFER_BYTES))
   `MFBR_ASSERT(a_partial_head, clock, reset, (off_ff != '0) |-> (level_ff != '0))
   `MFBR_ASSERT(a_span_bound, clock, reset, issue_cnt_ff <= MAX_SPAN_BYTES)
   `MFBR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `MFBR_ASSERT_NEXT(a_pos_hold, clock, reset, state_ff != ST_FINISH, $stable(head_ff) && $stable(off_ff))

endmodule
